// ===== hw/rtl/nwl_pkg.sv =====
// Shared types and constants for the nearest waypoint lookahead block.
package nwl_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned LOOK_W     = 10;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SEL_W      = ((ADDR_W > LOOK_W) ? ADDR_W : LOOK_W) + 1;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIST_W     = 2 * COORD_W + 1;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ANSWER = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_heading;
    logic signed [31:0] point_speed;
    logic signed [31:0] point_yaw_rate;
  } nwl_in_t;

  typedef struct packed {
    logic        [1:0]       status;
    logic        [IDX_W-1:0] found_index;
    logic signed [31:0]      out_x;
    logic signed [31:0]      out_y;
    logic signed [31:0]      out_heading;
    logic signed [31:0]      out_speed;
    logic signed [31:0]      out_yaw_rate;
  } nwl_out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] heading;
    logic [31:0] speed;
    logic [31:0] yaw_rate;
  } nwl_wp_t;

  typedef struct packed {
    logic       latch_in;
    logic       clear_cnt;
    logic       append;
    logic       scan_start;
    logic       scan_rd;
    logic       sel_calc;
    logic       sel_rd;
    logic       load_out;
    logic [1:0] out_status;
  } nwl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       empty;
    logic       full;
    logic       scan_last;
    logic       pipe_busy;
    logic       out_free;
  } nwl_sts_t;

endpackage

// ===== hw/rtl/nwl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nwl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nwl_datapath.sv =====
// Datapath: waypoint table, distance pipeline, best tracker, lookahead select, result register.
module nwl_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nwl_pkg::nwl_in_t          in_data_i,
  input  logic                      cfg_we_i,
  input  logic [nwl_pkg::LOOK_W-1:0] cfg_wdata_i,
  input  nwl_pkg::nwl_cmd_t         cmd_i,
  output nwl_pkg::nwl_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output nwl_pkg::nwl_out_t         out_data_o
);
  import nwl_pkg::*;

  nwl_in_t             in_q;
  logic [LOOK_W-1:0]   look_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   addr_q;
  logic [CNT_W-1:0]    last_idx;

  logic                v0_q, v1_q, v2_q;
  logic [ADDR_W-1:0]   idx0_q, idx1_q, idx2_q;
  logic [31:0]         dx_q, dy_q;
  logic [63:0]         sqx_q, sqy_q;
  logic [DIST_W-1:0]   best_dist_q;
  logic [ADDR_W-1:0]   best_idx_q;
  logic [ADDR_W-1:0]   sel_q;

  logic signed [32:0]  dx_full, dy_full;
  logic [32:0]         dx_abs, dy_abs;
  logic [DIST_W-1:0]   sq_sum;
  logic [SEL_W-1:0]    sel_sum;
  logic [SEL_W-1:0]    sel_lim;

  nwl_wp_t             wr_wp, rd_wp;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;

  logic                out_valid_q;
  nwl_out_t            out_q;
  logic                out_free;

  assign last_idx = cnt_q - CNT_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.command   = in_q.command;
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.full      = (cnt_q == CNT_W'(MAX_POINTS));
  assign sts_o.scan_last = (addr_q == last_idx[ADDR_W-1:0]);
  assign sts_o.pipe_busy = v0_q | v1_q | v2_q;
  assign sts_o.out_free  = out_free;

  assign wr_wp.x        = in_q.point_x;
  assign wr_wp.y        = in_q.point_y;
  assign wr_wp.heading  = in_q.point_heading;
  assign wr_wp.speed    = in_q.point_speed;
  assign wr_wp.yaw_rate = in_q.point_yaw_rate;

  assign ram_re    = cmd_i.scan_rd | cmd_i.sel_rd;
  assign ram_raddr = cmd_i.sel_rd ? sel_q : addr_q;

  nwl_ram #(
    .WIDTH ($bits(nwl_wp_t)),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (wr_wp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_wp)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q <= '0;
    end else if (cfg_we_i) begin
      look_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.append) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // advance scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.scan_start) begin
      addr_q <= '0;
    end else if (cmd_i.scan_rd) begin
      addr_q <= addr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.scan_rd;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  assign dx_full = $signed({rd_wp.x[31], rd_wp.x}) - $signed({in_q.point_x[31], in_q.point_x});
  assign dy_full = $signed({rd_wp.y[31], rd_wp.y}) - $signed({in_q.point_y[31], in_q.point_y});
  assign dx_abs  = dx_full[32] ? 33'(-dx_full) : 33'(dx_full);
  assign dy_abs  = dy_full[32] ? 33'(-dy_full) : 33'(dy_full);
  assign sq_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    idx0_q <= addr_q;
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    dx_q   <= dx_abs[31:0];
    dy_q   <= dy_abs[31:0];
    sqx_q  <= 64'(dx_q) * 64'(dx_q);
    sqy_q  <= 64'(dy_q) * 64'(dy_q);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ((idx2_q == '0) || (sq_sum < best_dist_q))) begin
      best_dist_q <= sq_sum;
      best_idx_q  <= idx2_q;
    end
  end

  assign sel_sum = SEL_W'(best_idx_q) + SEL_W'(look_q);
  assign sel_lim = SEL_W'(last_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_calc) begin
      sel_q <= (sel_sum > sel_lim) ? last_idx[ADDR_W-1:0] : sel_sum[ADDR_W-1:0];
    end
  end

  // hold result until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status <= cmd_i.out_status;
      if (cmd_i.out_status == STAT_ANSWER) begin
        out_q.found_index  <= IDX_W'(sel_q);
        out_q.out_x        <= rd_wp.x;
        out_q.out_y        <= rd_wp.y;
        out_q.out_heading  <= rd_wp.heading;
        out_q.out_speed    <= rd_wp.speed;
        out_q.out_yaw_rate <= rd_wp.yaw_rate;
      end else begin
        out_q.found_index  <= '0;
        out_q.out_x        <= '0;
        out_q.out_y        <= '0;
        out_q.out_heading  <= '0;
        out_q.out_speed    <= '0;
        out_q.out_yaw_rate <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/nwl_ctrl.sv =====
// Controller state machine: decode, scan, drain, select, fetch and respond.
module nwl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nwl_pkg::nwl_sts_t sts_i,
  output nwl_pkg::nwl_cmd_t cmd_o
);
  import nwl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_SEL    = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] resp_q, resp_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    cmd_o.out_status = resp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        resp_d  = STAT_DONE;
        case (sts_i.command)
          CMD_CLEAR: begin
            cmd_o.clear_cnt = 1'b1;
          end
          CMD_APPEND: begin
            if (sts_i.full) begin
              resp_d = STAT_FULL;
            end else begin
              cmd_o.append = 1'b1;
            end
          end
          CMD_QUERY: begin
            if (sts_i.empty) begin
              resp_d = STAT_EMPTY;
            end else begin
              cmd_o.scan_start = 1'b1;
              resp_d  = STAT_ANSWER;
              state_d = S_SCAN;
            end
          end
          default: begin
            resp_d = STAT_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.sel_calc = 1'b1;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.sel_rd = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= STAT_DONE;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

// ===== hw/rtl/nearest_waypoint_lookahead_top.sv =====
// Flow: clear and append go from the input register through decode to the respond state;
// a query on N stored waypoints reads the table once per cycle through a four-stage
// distance pipeline, drains it, selects the entry, then reads the chosen entry once.
// One item at a time: no new item is taken until the block is back in idle, but a
// new item is taken while a result waits for the receiver.
// Reset: table count, lookahead register and control clear asynchronously;
// table contents are not cleared and need no clearing pass.
module nearest_waypoint_lookahead_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  nwl_pkg::nwl_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output nwl_pkg::nwl_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [nwl_pkg::LOOK_W-1:0] cfg_wdata_i
);
  import nwl_pkg::*;

  nwl_cmd_t cmd;
  nwl_sts_t sts;

  nwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nwl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest waypoint lookahead block with a waypoint predictor.
module tb_top;
  import nwl_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int unsigned IDLE_LIMIT   = 10000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned FILL_ITEMS   = 40;
  localparam int unsigned PRINT_CAP    = 100;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  class waypoint_scoreboard;
    nwl_wp_t           path [MAX_POINTS];
    int unsigned       stored;
    logic [LOOK_W-1:0] lookahead;
    nwl_out_t          expected_q [$];
    int unsigned       mismatches, checked, taken, queries, drops, peak;

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t ERROR %s", $time, msg);
    endtask

    function logic [DIST_W-1:0] sq_dist(nwl_wp_t p, nwl_in_t q);
      longint            dx, dy;
      logic [DIST_W-1:0] ux, uy;
      dx = longint'($signed(p.x)) - longint'(q.point_x);
      dy = longint'($signed(p.y)) - longint'(q.point_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ux = DIST_W'(dx);
      uy = DIST_W'(dy);
      return ux * ux + uy * uy;
    endfunction

    function void note_transfer(nwl_in_t it);
      nwl_out_t          r;
      int unsigned       nearest, pick;
      logic [DIST_W-1:0] d, best_d;
      r = '0;
      taken++;
      case (it.command)
        CMD_CLEAR: stored = 0;
        CMD_APPEND: begin
          if (stored >= MAX_POINTS) begin
            r.status = STAT_FULL;
            drops++;
          end else begin
            path[stored] = {it.point_x, it.point_y, it.point_heading, it.point_speed,
                            it.point_yaw_rate};
            stored++;
            if (stored > peak) peak = stored;
          end
        end
        CMD_QUERY: begin
          if (stored == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            queries++;
            nearest = 0;
            best_d = sq_dist(path[0], it);
            for (int unsigned i = 1; i < stored; i++) begin
              d = sq_dist(path[i], it);
              if (d < best_d) begin
                best_d = d;
                nearest = i;
              end
            end
            pick = nearest + lookahead;
            if (pick > stored - 1) pick = stored - 1;
            r.status       = STAT_ANSWER;
            r.found_index  = IDX_W'(pick);
            r.out_x        = path[pick].x;
            r.out_y        = path[pick].y;
            r.out_heading  = path[pick].heading;
            r.out_speed    = path[pick].speed;
            r.out_yaw_rate = path[pick].yaw_rate;
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h want %h", checked, name, got, want));
    endtask

    task check_result(nwl_out_t got);
      nwl_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none pending: %h", got));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("status", got.status, want.status);
      compare_field("found_index", got.found_index, want.found_index);
      compare_field("out_x", got.out_x, want.out_x);
      compare_field("out_y", got.out_y, want.out_y);
      compare_field("out_heading", got.out_heading, want.out_heading);
      compare_field("out_speed", got.out_speed, want.out_speed);
      compare_field("out_yaw_rate", got.out_yaw_rate, want.out_yaw_rate);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  nwl_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  nwl_out_t          out_data_o;
  logic              cfg_we_i;
  logic [LOOK_W-1:0] cfg_wdata_i;

  waypoint_scoreboard sb;
  int unsigned        idle_cycles;
  int unsigned        sent;
  bit                 calm;
  bit                 hold_req;

  nearest_waypoint_lookahead_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (in_valid_i && !in_stall_o) sb.note_transfer(in_data_i);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("nearest_waypoint_lookahead_top: mismatch");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left = pick_gap(calm);
      end
    end
  end

  function automatic nwl_in_t make_item(logic [1:0] cmd, logic signed [31:0] x, y, h, s, w);
    nwl_in_t it;
    it.command        = cmd;
    it.point_x        = x;
    it.point_y        = y;
    it.point_heading  = h;
    it.point_speed    = s;
    it.point_yaw_rate = w;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $signed(32'($urandom_range(0, 32'h0006_0000))) - 32'sh0003_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] jitter();
    if ($urandom_range(0, 2) == 0) return '0;
    return $signed(32'($urandom_range(0, 512))) - 32'sd256;
  endfunction

  function automatic nwl_in_t rand_append();
    nwl_in_t     it;
    int unsigned k;
    it = make_item(CMD_APPEND, rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
    if (sb.stored != 0 && $urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, sb.stored - 1);
      it.point_x = sb.path[k].x;
      it.point_y = sb.path[k].y;
    end
    return it;
  endfunction

  function automatic nwl_in_t rand_query();
    nwl_in_t     it;
    int unsigned k;
    it = make_item(CMD_QUERY, rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
    if (sb.stored != 0 && $urandom_range(0, 2) != 0) begin
      k = $urandom_range(0, sb.stored - 1);
      it.point_x = sb.path[k].x + jitter();
      it.point_y = sb.path[k].y + jitter();
    end
    return it;
  endfunction

  task automatic send(nwl_in_t it);
    int unsigned gap;
    gap = pick_gap(calm);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_lookahead(logic [LOOK_W-1:0] v);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    sb.lookahead = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_phase(int unsigned points, int unsigned asks);
    send(make_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
    repeat (points) send(rand_append());
    repeat (asks) begin
      case ($urandom_range(0, 19))
        0: send(make_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                          $urandom));
        1: drain();
        2, 3: send(rand_append());
        default: send(rand_query());
      endcase
    end
  endtask

  initial begin
    int unsigned       points, big_left, stop_at;
    logic [LOOK_W-1:0] look;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_lookahead('0);
    send(make_item(CMD_QUERY, S_MAX, S_MIN, '0, '0, '0));
    send(make_item(CMD_NOP, S_MIN, S_MAX, '1, '1, '1));
    send(make_item(CMD_APPEND, S_MIN, S_MIN, S_MAX, S_MIN, -1));
    send(make_item(CMD_APPEND, S_MIN, S_MAX, '0, S_MAX, 32'sd1));
    // squared distance to the first entry carries past 64 bits
    send(make_item(CMD_QUERY, S_MAX, S_MAX, '0, '0, '0));
    send(make_item(CMD_QUERY, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX));
    send(make_item(CMD_APPEND, '0, '0, 32'sh0001_0000, 32'sh0002_8000, -32'sh0000_8000));
    send(make_item(CMD_APPEND, '0, '0, S_MAX, S_MAX, S_MAX));
    send(make_item(CMD_APPEND, S_MAX, S_MIN, S_MIN, '0, S_MIN));
    send(make_item(CMD_QUERY, '0, '0, '0, '0, '0));
    send(make_item(CMD_QUERY, 32'sd1, -32'sd1, '1, '1, '1));
    send(make_item(CMD_QUERY, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX));
    send(make_item(CMD_NOP, '0, '0, '0, '0, '0));
    send(make_item(CMD_QUERY, '0, '0, '0, '0, '0));
    send(make_item(CMD_CLEAR, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
    send(make_item(CMD_QUERY, '0, '0, '0, '0, '0));
    send(make_item(CMD_APPEND, 32'sh0001_0000, 32'sh0001_0000, 32'sd11, 32'sd12, 32'sd13));
    send(make_item(CMD_APPEND, 32'sh0002_0000, 32'sh0002_0000, 32'sd21, 32'sd22, 32'sd23));
    send(make_item(CMD_APPEND, 32'sh0003_0000, 32'sh0003_0000, 32'sd31, 32'sd32, 32'sd33));
    write_lookahead('1);
    send(make_item(CMD_QUERY, 32'sh0001_0100, 32'sh0000_ff00, '0, '0, '0));
    write_lookahead(10'd1);
    send(make_item(CMD_QUERY, 32'sh0001_0100, 32'sh0000_ff00, '0, '0, '0));
    send(make_item(CMD_QUERY, 32'sh0003_0000, 32'sh0003_0000, '0, '0, '0));
    send(make_item(CMD_QUERY, 32'sh0002_0000, 32'sh0002_0000, '0, '0, '0));

    big_left = 2;
    stop_at = sent + RANDOM_ITEMS;
    while (sent < stop_at) begin
      case ($urandom_range(0, 5))
        0: look = '0;
        1: look = '1;
        2: look = LOOK_W'($urandom_range(0, 1023));
        default: look = LOOK_W'($urandom_range(0, 3));
      endcase
      write_lookahead(look);
      calm <= ($urandom_range(0, 4) == 0);
      points = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) points = $urandom_range(13, 64);
      if (big_left != 0 && $urandom_range(0, 15) == 0) begin
        points = $urandom_range(150, 300);
        big_left--;
      end
      if (points > stop_at - sent) points = stop_at - sent;
      run_phase(points, $urandom_range(4, 12));
    end

    // keep appending while the receiver holds off, then query the result
    write_lookahead('0);
    calm <= 1'b1;
    hold_req <= 1'b1;
    send(make_item(CMD_CLEAR, '0, '0, '0, '0, '0));
    repeat (FILL_ITEMS) send(rand_append());
    calm <= 1'b0;
    repeat (3) send(rand_query());
    write_lookahead('1);
    send(rand_query());
    write_lookahead(LOOK_W'($urandom_range(1, 3)));
    repeat (2) send(rand_query());
    send(make_item(CMD_CLEAR, '0, '0, '0, '0, '0));
    send(rand_query());

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("run covered %0d transfers in, %0d results checked, %0d answered queries",
             sb.taken, sb.checked, sb.queries);
    $display("largest table %0d waypoints, %0d appends dropped when full, %0d mismatches",
             sb.peak, sb.drops, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("nearest_waypoint_lookahead_top: match");
    end else begin
      $display("nearest_waypoint_lookahead_top: mismatch");
    end
    $finish;
  end

endmodule
